FILE: hw/rtl/vlse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlse_pkg
// Shared constants and exp/ln tables for vector log-sum-exp.
// ----------------------------------------------------------------------------
package vlse_pkg;

	localparam int unsigned SAMPLE_WIDTH = 16;
	localparam int unsigned ACC_W = 25;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam int unsigned LN2_Q16 = 45426;

	function automatic logic [16:0] exp_int(input logic [3:0] a);
		case (a)
			4'd0: return 17'd65536;
			4'd1: return 17'd24109;
			4'd2: return 17'd8869;
			4'd3: return 17'd3263;
			4'd4: return 17'd1200;
			4'd5: return 17'd442;
			4'd6: return 17'd162;
			4'd7: return 17'd60;
			4'd8: return 17'd22;
			4'd9: return 17'd8;
			4'd10: return 17'd3;
			4'd11: return 17'd1;
			default: return 17'd0;
		endcase
	endfunction

	function automatic logic [16:0] exp_hi(input logic [3:0] b);
		case (b)
			4'd0: return 17'd65536;
			4'd1: return 17'd61565;
			4'd2: return 17'd57835;
			4'd3: return 17'd54331;
			4'd4: return 17'd51039;
			4'd5: return 17'd47947;
			4'd6: return 17'd45042;
			4'd7: return 17'd42313;
			4'd8: return 17'd39750;
			4'd9: return 17'd37341;
			4'd10: return 17'd35079;
			4'd11: return 17'd32954;
			4'd12: return 17'd30957;
			4'd13: return 17'd29081;
			4'd14: return 17'd27319;
			default: return 17'd25664;
		endcase
	endfunction

	function automatic logic [16:0] exp_lo(input logic [3:0] c);
		case (c)
			4'd0: return 17'd65536;
			4'd1: return 17'd65280;
			4'd2: return 17'd65026;
			4'd3: return 17'd64772;
			4'd4: return 17'd64520;
			4'd5: return 17'd64268;
			4'd6: return 17'd64018;
			4'd7: return 17'd63768;
			4'd8: return 17'd63520;
			4'd9: return 17'd63272;
			4'd10: return 17'd63025;
			4'd11: return 17'd62780;
			4'd12: return 17'd62535;
			4'd13: return 17'd62291;
			4'd14: return 17'd62048;
			default: return 17'd61806;
		endcase
	endfunction

	function automatic logic [15:0] ln_tab(input logic [4:0] i);
		case (i)
			5'd0: return 16'd0;
			5'd1: return 16'd3973;
			5'd2: return 16'd7719;
			5'd3: return 16'd11262;
			5'd4: return 16'd14624;
			5'd5: return 16'd17821;
			5'd6: return 16'd20870;
			5'd7: return 16'd23783;
			5'd8: return 16'd26573;
			5'd9: return 16'd29248;
			5'd10: return 16'd31818;
			5'd11: return 16'd34292;
			5'd12: return 16'd36675;
			5'd13: return 16'd38975;
			5'd14: return 16'd41196;
			5'd15: return 16'd43345;
			default: return 16'd45426;
		endcase
	endfunction

endpackage

FILE: hw/rtl/vlse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlse_front
// Accepts samples, stores them, tracks running max; hands a vector job to
// the back end through a one-entry job register when the last sample lands.
// ----------------------------------------------------------------------------
module vlse_front #(
	parameter int unsigned MAX_ELEMENTS = 256,
	parameter int unsigned CNT_W = 9,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [vlse_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                              last_element,
	input  logic [ADDR_W-1:0]                 rd_addr,
	output logic [vlse_pkg::SAMPLE_WIDTH-1:0] rd_data,
	output logic                              job_valid,
	input  logic                              job_take,
	output logic [CNT_W-1:0]                  job_count,
	output logic [vlse_pkg::SAMPLE_WIDTH-1:0] job_max,
	output logic                              job_ovf,
	input  logic                              back_busy
);
	import vlse_pkg::*;

	logic [SAMPLE_WIDTH-1:0] mem_q [MAX_ELEMENTS];
	logic [CNT_W-1:0]        count_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic                    ovf_q;
	logic                    acc;
	logic                    room;
	logic signed [SAMPLE_WIDTH-1:0] xs;
	logic signed [SAMPLE_WIDTH-1:0] new_max;

	// a finished vector must drain before the store is reused
	assign full = job_valid || back_busy;
	assign acc  = push && !full;
	assign room = count_q < CNT_W'(MAX_ELEMENTS);
	assign xs   = sample;
	assign new_max = (count_q == '0 || xs > max_q) ? xs : max_q;

	always_ff @(posedge clk) begin
		if (acc && room) begin
			mem_q[count_q[ADDR_W-1:0]] <= sample;
		end
		rd_data <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			max_q     <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			ovf_q     <= 1'b0;
			job_valid <= 1'b0;
			job_count <= '0;
			job_max   <= '0;
			job_ovf   <= 1'b0;
		end else begin
			if (job_take) begin
				job_valid <= 1'b0;
			end
			if (acc) begin
				if (last_element) begin
					job_valid <= 1'b1;
					job_count <= room ? count_q + 1'b1 : count_q;
					job_max   <= room ? new_max : max_q;
					job_ovf   <= ovf_q || !room;
					count_q   <= '0;
					max_q     <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
					ovf_q     <= 1'b0;
				end else if (room) begin
					count_q <= count_q + 1'b1;
					max_q   <= new_max;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/vlse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlse_back
// Sweeps stored samples, accumulates exp terms, then forms the log, rounds
// and saturates. Result held in an output register until popped.
// ----------------------------------------------------------------------------
module vlse_back #(
	parameter int unsigned CNT_W = 9,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic [ADDR_W-1:0]                 rd_addr,
	input  logic [vlse_pkg::SAMPLE_WIDTH-1:0] rd_data,
	input  logic                              job_valid,
	output logic                              job_take,
	input  logic [CNT_W-1:0]                  job_count,
	input  logic [vlse_pkg::SAMPLE_WIDTH-1:0] job_max,
	input  logic                              job_ovf,
	output logic                              busy,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [15:0]                log_sum,
	output logic                              overflowed
);
	import vlse_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_LOG  = 3'd4;
	localparam logic [2:0] ST_LN   = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;
	localparam int unsigned M_W = SAMPLE_WIDTH + 1;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] issued_q;
	logic [CNT_W-1:0] len_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic             ovf_q;
	logic             rd_v_s1;
	logic [M_W-1:0]   m_s2;
	logic             v_s2;
	logic [16:0]      f_s3;
	logic [3:0]       a_s3;
	logic             v_s3;
	logic             z_s3;
	logic [16:0]      t_s4;
	logic             v_s4;
	logic [ACC_W-1:0] acc_q;
	logic [4:0]       p_q;
	logic [22:0]      frac_q;
	logic signed [23:0] r_q;
	logic [M_W-1:0]   m_c;
	logic [33:0]      hl;
	logic [33:0]      fi;
	logic [ACC_W:0]   sum;
	logic [4:0]       p_c;
	logic [ACC_W+23:0] sh;
	logic [15:0]      ln_a;
	logic [15:0]      ln_b;
	logic [34:0]      interp;
	logic signed [24:0] rr;
	logic signed [SAMPLE_WIDTH+1:0] y;
	logic signed [SAMPLE_WIDTH+1:0] q_ext;

	assign busy     = state_q != ST_IDLE;
	assign job_take = job_valid && state_q == ST_IDLE;
	assign rd_addr  = issued_q[ADDR_W-1:0];

	assign m_c = M_W'(max_q) - M_W'($signed(rd_data));
	assign hl  = exp_hi(m_s2[7:4]) * exp_lo(m_s2[3:0]) + 34'd32768;
	assign fi  = f_s3 * exp_int(a_s3) + 34'd32768;
	assign sum = {1'b0, acc_q} + (ACC_W+1)'(t_s4);

	always_comb begin
		p_c = '0;
		for (int k = 0; k < ACC_W; k++) begin
			if (acc_q[k]) begin
				p_c = 5'(k);
			end
		end
	end

	assign sh     = {23'd0, acc_q} << (6'd46 - {1'b0, p_c});
	assign ln_a   = ln_tab({1'b0, frac_q[22:19]});
	assign ln_b   = ln_tab({1'b0, frac_q[22:19]} + 5'd1);
	assign interp = (ln_b - ln_a) * frac_q[18:0];
	assign rr     = 25'(r_q) + 25'sd128;
	assign q_ext  = (SAMPLE_WIDTH+2)'(rr >>> 8);
	assign y      = (SAMPLE_WIDTH+2)'(max_q) + q_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			issued_q <= '0;
			len_q    <= '0;
			rd_v_s1  <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			acc_q    <= '0;
			empty    <= 1'b1;
		end else begin
			rd_v_s1 <= 1'b0;
			v_s2    <= rd_v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (v_s4) begin
				acc_q <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
				cnt_q <= cnt_q + 1'b1;
			end
			if (!empty && pop) begin
				empty <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q  <= ST_RUN;
						len_q    <= job_count;
						issued_q <= '0;
						cnt_q    <= '0;
						acc_q    <= '0;
					end
				end
				ST_RUN: begin
					if (issued_q != len_q) begin
						rd_v_s1  <= 1'b1;
						issued_q <= issued_q + 1'b1;
					end
					if (v_s4 && cnt_q + 1'b1 == len_q) begin
						state_q <= ST_LOG;
					end
				end
				ST_LOG: state_q <= ST_LN;
				ST_LN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (empty || pop) begin
						empty   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			max_q <= job_max;
			ovf_q <= job_ovf;
		end
		m_s2 <= m_c;
		a_s3 <= m_s2[11:8];
		z_s3 <= m_s2[M_W-1:8] >= 12;
		f_s3 <= 17'(hl >> 16);
		t_s4 <= z_s3 ? 17'd0 : ((fi >> 16) > 34'd65535 ? 17'd65535 : 17'(fi >> 16));
		if (state_q == ST_LOG) begin
			p_q    <= p_c;
			frac_q <= sh[45:23];
		end
		if (state_q == ST_LN) begin
			r_q <= (acc_q == '0) ? 24'sd0 :
				24'($signed({1'b0, p_q}) - 6'sd16) * 24'sd45426
				+ 24'(ln_a) + 24'(interp >> 19);
		end
		if (state_q == ST_OUT && (empty || pop)) begin
			overflowed <= ovf_q;
			if (y > 32767) begin
				log_sum <= 16'sd32767;
			end else if (y < -32768) begin
				log_sum <= -16'sd32768;
			end else begin
				log_sum <= 16'(y);
			end
		end
	end

	// frac of sh: leading one moved to bit 46, so bits 45:23 are the fraction
	logic unused_ok;
	assign unused_ok = ^{v_s3, sh[ACC_W+23:46], sh[22:0]};

endmodule

FILE: hw/rtl/vector_log_sum_exp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_log_sum_exp_top
// Log-sum-exp over a vector of Q7.8 samples.
//   channel | handshake   | fields
//   input   | push / full | sample, last_element
//   result  | pop / empty | log_sum, overflowed
// One sample per cycle while loading and full is low. On the last sample the
// back end sweeps the store through one read port and a four-stage exp
// pipeline, then holds the result until popped.
// full is high while a vector is being evaluated. Reset clears all counters.
// ----------------------------------------------------------------------------
module vector_log_sum_exp_top #(
	parameter int unsigned MAX_ELEMENTS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [vlse_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                              last_element,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [15:0]                log_sum,
	output logic                              overflowed
);
	import vlse_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic [ADDR_W-1:0]       rd_addr;
	logic [SAMPLE_WIDTH-1:0] rd_data;
	logic                    job_valid;
	logic                    job_take;
	logic [CNT_W-1:0]        job_count;
	logic [SAMPLE_WIDTH-1:0] job_max;
	logic                    job_ovf;
	logic                    back_busy;

	vlse_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS), .CNT_W(CNT_W), .ADDR_W(ADDR_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.last_element(last_element), .rd_addr(rd_addr), .rd_data(rd_data),
		.job_valid(job_valid), .job_take(job_take), .job_count(job_count),
		.job_max(job_max), .job_ovf(job_ovf), .back_busy(back_busy)
	);

	vlse_back #(
		.CNT_W(CNT_W), .ADDR_W(ADDR_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .rd_addr(rd_addr), .rd_data(rd_data),
		.job_valid(job_valid), .job_take(job_take), .job_count(job_count),
		.job_max(job_max), .job_ovf(job_ovf), .busy(back_busy), .empty(empty),
		.pop(pop), .log_sum(log_sum), .overflowed(overflowed)
	);

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> back_busy) else $error("job taken but back end idle");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_busy |-> full) else $error("input open during evaluation");
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> job_count != '0) else $error("empty vector job");

endmodule
